[rtl/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg: shared types, constants and step functions
// Formats, CORDIC angle table and the per-stage arithmetic of the quaternion
// to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int QIN_W       = 32;
  localparam int Q14_W       = 16;
  localparam int PROD_W      = 32;
  localparam int TERM_W      = 34;  // 2*(a*b +- c*d), Q.28
  localparam int S_W         = 30;  // clamped asin argument, within +-2^28
  localparam int SM_W        = 29;  // magnitude of it
  localparam int SQ_W        = 57;  // 2^56 - sm^2
  localparam int ISQ_STAGES  = 29;  // one result bit per stage, 2^56 down to 2^0
  localparam int CRD_W       = 36;  // CORDIC x, y and angle accumulator
  localparam int ATAN_LEN    = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int YAW_W       = 16;
  localparam int PITCH_W     = 15;
  localparam int ROLL_W      = 16;
  localparam int RND_W       = 19;  // angle after the Q.30 to Q2.13 shift

  localparam logic signed [CRD_W-1:0]  PI_Q30   = 36'sd3373259426;
  localparam logic signed [TERM_W-1:0] ONE_Q28  = 34'sd268435456;
  localparam logic signed [RND_W-1:0]  LIM_FULL = 19'sd25736;
  localparam logic signed [RND_W-1:0]  LIM_HALF = 19'sd12868;

  // Products and sums that feed the three angle computations.
  typedef struct packed {
    logic signed [TERM_W-1:0] yaw_num;
    logic signed [TERM_W-1:0] yaw_den;
    logic signed [TERM_W-1:0] roll_num;
    logic signed [TERM_W-1:0] roll_den;
    logic signed [S_W-1:0]    pitch_s;
    logic                     clamped;
  } terms_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } isq_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic                    zero;
  } cord_t;

  function automatic logic signed [CRD_W-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({4'b0, v});
  endfunction

  // One digit of the floor square root; the trial bit is 2^(56-2k).
  function automatic isq_t isq_step(input isq_t a, input int k);
    logic [SQ_W:0] bit_v;
    logic [SQ_W:0] trial;
    isq_t          o;
    bit_v = (SQ_W+1)'(1) << (SQ_W - 1 - 2 * k);
    trial = {1'b0, a.res} + bit_v;
    if ({1'b0, a.rem} >= trial) begin
      o.rem = a.rem - trial[SQ_W-1:0];
      o.res = (a.res >> 1) + bit_v[SQ_W-1:0];
    end else begin
      o.rem = a.rem;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  // Vectoring-mode micro-rotation i.
  function automatic cord_t cord_step(input cord_t a, input int i);
    cord_t o;
    o = a;
    if (a.y > 0) begin
      o.x = a.x + (a.y >>> i);
      o.y = a.y - (a.x >>> i);
      o.z = a.z + atan_q30(i);
    end else begin
      o.x = a.x - (a.y >>> i);
      o.y = a.y + (a.x >>> i);
      o.z = a.z - atan_q30(i);
    end
    return o;
  endfunction

  // Quadrant fix-up before the micro-rotations.
  function automatic cord_t cord_init(input logic signed [CRD_W-1:0] y,
                                      input logic signed [CRD_W-1:0] x);
    cord_t o;
    o.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      o.z = (y >= 0) ? PI_Q30 : -PI_Q30;
      o.x = -x;
      o.y = -y;
    end else begin
      o.z = '0;
      o.x = x;
      o.y = y;
    end
    return o;
  endfunction

  // Round half up from Q.30 to Q2.13 and saturate to +-lim.
  function automatic logic signed [RND_W-1:0] to_q13(input logic signed [CRD_W-1:0] z,
                                                     input logic signed [RND_W-1:0] lim);
    logic signed [CRD_W-1:0] t;
    logic signed [RND_W-1:0] r;
    t = (z + 36'sd65536) >>> 17;
    r = t[RND_W-1:0];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

[rtl/quaternion_to_euler_angles_top.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: quaternion to yaw, pitch and roll
// Pipelined products, floor square root and three vectoring CORDICs.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one quaternion on in_tdata (w, x, y, z, 32 bits each,
//   only the upper 16 bits of each are used as Q2.14). Output beats carry
//   yaw, pitch, roll in Q2.13 radians and a flag that is set when the asin
//   argument had to be clamped to plus or minus one.
//   Throughput is one beat per cycle unless the output stalls. A beat passes
//   through the input register, products, sums, square, subtraction, 29
//   square root stages, quadrant fix-up, CORDIC_STEPS micro-rotation stages
//   (at most ATAN_LEN) and the rounding stage into the output register.
//   The square root pipeline sets most of the depth.
//   The whole pipeline moves as one: when the output register holds a beat
//   that the receiver does not take, every stage holds and in_tready drops;
//   nothing is lost or repeated. Reset clears all valid bits, the output
//   valid among them; there is no other state and no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata   // yaw_angle, pitch_angle, roll_angle, pitch_clamped
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input register.
  logic                    v_in_r;
  logic signed [Q14_W-1:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_in_r <= 1'b0;
    else if (en) v_in_r <= in_tvalid;
    if (en) begin
      w_r <= $signed(in_tdata[31:16]);
      x_r <= $signed(in_tdata[63:48]);
      y_r <= $signed(in_tdata[95:80]);
      z_r <= $signed(in_tdata[127:112]);
    end
  end

  // Products.
  logic                     v_pr_r;
  logic signed [PROD_W-1:0] xy_r, wz_r, ww_r, xx_r, xz_r, wy_r, yz_r, wx_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_pr_r <= 1'b0;
    else if (en) v_pr_r <= v_in_r;
    if (en) begin
      xy_r <= x_r * y_r;
      wz_r <= w_r * z_r;
      ww_r <= w_r * w_r;
      xx_r <= x_r * x_r;
      xz_r <= x_r * z_r;
      wy_r <= w_r * y_r;
      yz_r <= y_r * z_r;
      wx_r <= w_r * x_r;
      zz_r <= z_r * z_r;
    end
  end

  // Sums and clamp of the asin argument.
  terms_t                   terms_nxt;
  logic signed [TERM_W-1:0] s_full;
  logic [SM_W-1:0]          sm_nxt;

  always_comb begin
    terms_nxt.yaw_num  = (TERM_W'(xy_r) - TERM_W'(wz_r)) <<< 1;
    terms_nxt.yaw_den  = ((TERM_W'(ww_r) + TERM_W'(xx_r)) <<< 1) - ONE_Q28;
    terms_nxt.roll_num = (TERM_W'(yz_r) - TERM_W'(wx_r)) <<< 1;
    terms_nxt.roll_den = ((TERM_W'(ww_r) + TERM_W'(zz_r)) <<< 1) - ONE_Q28;
    s_full             = (TERM_W'(xz_r) + TERM_W'(wy_r)) <<< 1;
    terms_nxt.clamped  = 1'b0;
    if (s_full > ONE_Q28) begin
      s_full            = ONE_Q28;
      terms_nxt.clamped = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      s_full            = -ONE_Q28;
      terms_nxt.clamped = 1'b1;
    end
    terms_nxt.pitch_s = s_full[S_W-1:0];
    sm_nxt = s_full[TERM_W-1] ? SM_W'(-s_full) : SM_W'(s_full);
  end

  logic            v_sum_r;
  terms_t          t_sum_r;
  logic [SM_W-1:0] sm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_sum_r <= 1'b0;
    else if (en) v_sum_r <= v_pr_r;
    if (en) begin
      t_sum_r <= terms_nxt;
      sm_r    <= sm_nxt;
    end
  end

  // Square of the magnitude.
  logic            v_sq_r;
  terms_t          t_sq_r;
  logic [SQ_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_sq_r <= 1'b0;
    else if (en) v_sq_r <= v_sum_r;
    if (en) begin
      t_sq_r <= t_sum_r;
      sq_r   <= SQ_W'(sm_r * sm_r);
    end
  end

  // Radicand 1 - s^2 and the square root pipeline.
  logic   v_isq_r [0:ISQ_STAGES];
  terms_t t_isq_r [0:ISQ_STAGES];
  isq_t   isq_r   [0:ISQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) v_isq_r[0] <= 1'b0;
    else if (en) v_isq_r[0] <= v_sq_r;
    if (en) begin
      t_isq_r[0]   <= t_sq_r;
      isq_r[0].rem <= (SQ_W'(1) << (SQ_W - 1)) - sq_r;
      isq_r[0].res <= '0;
    end
  end

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
    always_ff @(posedge clk) begin
      if (!rst_n) v_isq_r[k+1] <= 1'b0;
      else if (en) v_isq_r[k+1] <= v_isq_r[k];
      if (en) begin
        t_isq_r[k+1] <= t_isq_r[k];
        isq_r[k+1]   <= isq_step(isq_r[k], k);
      end
    end
  end

  // Quadrant fix-up for the three CORDIC channels: yaw, pitch, roll.
  logic  v_cd_r [0:NSTEP];
  logic  cl_cd_r [0:NSTEP];
  cord_t cd_r [0:2][0:NSTEP];

  always_ff @(posedge clk) begin
    if (!rst_n) v_cd_r[0] <= 1'b0;
    else if (en) v_cd_r[0] <= v_isq_r[ISQ_STAGES];
    if (en) begin
      cl_cd_r[0] <= t_isq_r[ISQ_STAGES].clamped;
      cd_r[0][0] <= cord_init(CRD_W'(t_isq_r[ISQ_STAGES].yaw_num),
                              CRD_W'(t_isq_r[ISQ_STAGES].yaw_den));
      cd_r[1][0] <= cord_init(CRD_W'(t_isq_r[ISQ_STAGES].pitch_s),
                              $signed({{(CRD_W-SM_W){1'b0}},
                                       isq_r[ISQ_STAGES].res[SM_W-1:0]}));
      cd_r[2][0] <= cord_init(CRD_W'(t_isq_r[ISQ_STAGES].roll_num),
                              CRD_W'(t_isq_r[ISQ_STAGES].roll_den));
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cord
    always_ff @(posedge clk) begin
      if (!rst_n) v_cd_r[i+1] <= 1'b0;
      else if (en) v_cd_r[i+1] <= v_cd_r[i];
      if (en) begin
        cl_cd_r[i+1] <= cl_cd_r[i];
        cd_r[0][i+1] <= cord_step(cd_r[0][i], i);
        cd_r[1][i+1] <= cord_step(cd_r[1][i], i);
        cd_r[2][i+1] <= cord_step(cd_r[2][i], i);
      end
    end
  end

  // Rounding, saturation and the output register.
  logic signed [CRD_W-1:0] yaw_z, pitch_z, roll_z;
  logic signed [RND_W-1:0] yaw_q, pitch_q, roll_q;
  logic [47:0]             out_tdata_nxt;
  logic                    out_tvalid_r;
  logic [47:0]             out_tdata_r;

  always_comb begin
    yaw_z   = cd_r[0][NSTEP].zero ? '0 : cd_r[0][NSTEP].z;
    pitch_z = cd_r[1][NSTEP].zero ? '0 : -cd_r[1][NSTEP].z;
    roll_z  = cd_r[2][NSTEP].zero ? '0 : cd_r[2][NSTEP].z;
    yaw_q   = to_q13(yaw_z, LIM_FULL);
    pitch_q = to_q13(pitch_z, LIM_HALF);
    roll_q  = to_q13(roll_z, LIM_FULL);
    out_tdata_nxt = {cl_cd_r[NSTEP], roll_q[ROLL_W-1:0], pitch_q[PITCH_W-1:0],
                     yaw_q[YAW_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= v_cd_r[NSTEP];
    if (en) out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A clamped pitch is always a right angle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[47] |->
      ($signed(out_tdata[30:16]) == LIM_HALF[PITCH_W-1:0]) ||
      ($signed(out_tdata[30:16]) == -LIM_HALF[PITCH_W-1:0]))
    else $error("clamped pitch is not a right angle");

  // A stalled output keeps its beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // A beat accepted at the input leaves the first stage valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_in_r)
    else $error("accepted beat dropped at input register");

  // Yaw and roll angles stay within their ranges.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd25736) &&
                   ($signed(out_tdata[15:0]) >= -16'sd25736) &&
                   ($signed(out_tdata[46:31]) <= 16'sd25736) &&
                   ($signed(out_tdata[46:31]) >= -16'sd25736))
    else $error("angle out of range");

endmodule

[tb/tb_quaternion_to_euler_angles_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top: self-checking bench for the converter
// A queue of quaternions feeds a stream driver. Each accepted beat is run
// through a bit-exact integer predictor, and the output beats are compared
// field by field with the oldest predicted angles. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_top;
  import q2e_pkg::*;

  localparam int       ROT_STEPS  = CORDIC_STEPS_DEF;
  localparam int       PIPE_DEPTH = 35 + ROT_STEPS;
  localparam int       CYCLE_LIM  = 200000;
  localparam longint   ONE_FIX    = 64'sd268435456;
  localparam longint   PI_FIX     = 64'sd3373259426;
  localparam longint   ANG_TAB [24] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
  localparam int       FLD_LO [4] = '{0, 16, 31, 47};
  localparam int       FLD_WD [4] = '{16, 15, 16, 1};
  localparam string    FLD_NM [4] = '{"yaw_angle", "pitch_angle", "roll_angle",
                                      "pitch_clamped"};

  typedef struct {
    logic [127:0] quat;
    bit           drain;  // hold the sender until all angles are back
  } quat_beat_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // quat_w, quat_x, quat_y, quat_z
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;  // yaw_angle, pitch_angle, roll_angle, pitch_clamped

  quat_beat_t   quat_q[$];
  logic [47:0]  angles_q[$];
  bit           in_taken;
  int           errors;
  int           cycles;

  quaternion_to_euler_angles_top dut (.*);

  function automatic longint rot_angle(longint yv, longint xv);
    longint zv, dx, dy;
    zv = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zv = (yv >= 0) ? PI_FIX : -PI_FIX;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx; yv -= dy; zv += ANG_TAB[i];
      end else begin
        xv -= dx; yv += dy; zv -= ANG_TAB[i];
      end
    end
    return zv;
  endfunction

  function automatic longint round_sat(longint zv, longint lim);
    longint r;
    r = (zv + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Packs yaw, pitch, roll and the clamp flag as the output beat does.
  function automatic logic [47:0] euler_of(logic [127:0] q);
    longint w, x, y, z, yn, yd, s, rn, rd, yaw, pitch, roll;
    longint unsigned sm, c;
    bit clamp;
    w = longint'($signed(q[31:16]));
    x = longint'($signed(q[63:48]));
    y = longint'($signed(q[95:80]));
    z = longint'($signed(q[127:112]));
    yn = 2 * (x * y - w * z);
    yd = 2 * (w * w + x * x) - ONE_FIX;
    s  = 2 * (x * z + w * y);
    rn = 2 * (y * z - w * x);
    rd = 2 * (w * w + z * z) - ONE_FIX;
    clamp = 0;
    if (s > ONE_FIX) begin s = ONE_FIX; clamp = 1; end
    if (s < -ONE_FIX) begin s = -ONE_FIX; clamp = 1; end
    sm = (s < 0) ? -s : s;
    c = floor_root((64'd1 << 56) - sm * sm);
    yaw   = round_sat(rot_angle(yn, yd), 25736);
    pitch = round_sat(-rot_angle(s, longint'(c)), 12868);
    roll  = round_sat(rot_angle(rn, rd), 25736);
    return {clamp, roll[15:0], pitch[14:0], yaw[15:0]};
  endfunction

  function automatic logic [31:0] comp(logic [15:0] hi);
    return {hi, 16'($urandom)};
  endfunction

  function automatic void push_quat(logic [15:0] w, logic [15:0] x,
                                    logic [15:0] y, logic [15:0] z);
    quat_beat_t b;
    b.quat  = {comp(z), comp(y), comp(x), comp(w)};
    b.drain = 0;
    quat_q.push_back(b);
  endfunction

  function automatic logic [15:0] near_unit();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Random stalls, with a quiet window where both sides run flat out.
  function automatic bit stall_now();
    return !(cycles > 200 && cycles < 500) && ($urandom_range(99) < 10);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIM) begin
      $display("FAIL");
      $finish;
    end
  end

  // Predict at acceptance; the input beat is stable at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      angles_q.push_back(euler_of(in_tdata));
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    quat_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 0;
      if (quat_q.size() != 0 && quat_q[0].drain) begin
        in_tvalid <= 0;
        if (angles_q.size() == 0) void'(quat_q.pop_front());
      end else if (quat_q.size() != 0 && !stall_now()) begin
        nb = quat_q.pop_front();
        in_tdata  <= nb.quat;
        in_tvalid <= 1;
      end else begin
        in_tvalid <= 0;
      end
    end
    out_tready <= rst_n && !stall_now();
  end

  always @(posedge clk) begin
    logic [47:0] want;
    logic [47:0] mask;
    if (rst_n && out_tvalid && out_tready) begin
      if (angles_q.size() == 0) begin
        $display("%0t: output beat with no quaternion pending, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = angles_q.pop_front();
        for (int f = 0; f < 4; f++) begin
          mask = (48'd1 << FLD_WD[f]) - 1;
          if (((want >> FLD_LO[f]) & mask) != ((out_tdata >> FLD_LO[f]) & mask)) begin
            $display("%0t: %s expected %h actual %h", $time, FLD_NM[f],
                     (want >> FLD_LO[f]) & mask, (out_tdata >> FLD_LO[f]) & mask);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    quat_beat_t hold;
    errors = 0;
    cycles = 0;
    in_taken = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;

    // Directed: zero vector, identity, extreme codes, pi flips and clamps.
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    push_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    push_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    push_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    push_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    push_quat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
    push_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
    push_quat(16'h3000, 16'h0000, 16'h3000, 16'h0000);
    push_quat(16'h3000, 16'h0000, 16'hD000, 16'h0000);
    push_quat(16'h0000, 16'h3000, 16'h0000, 16'h3000);
    push_quat(16'h2000, 16'h2000, 16'hE000, 16'h2000);
    push_quat(16'h0000, 16'h2D41, 16'h2D41, 16'h0000);
    push_quat(16'h0000, 16'h2D41, 16'hD2BF, 16'h0000);
    push_quat(16'h1000, 16'h0000, 16'h0000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'hC000);
    hold.quat = '0;
    hold.drain = 1;
    quat_q.push_back(hold);

    for (int n = 0; n < 800; n++) begin
      if (n == 400) quat_q.push_back(hold);
      if ($urandom_range(3) == 0)
        push_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        push_quat(near_unit(), near_unit(), near_unit(), near_unit());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1;

    wait (quat_q.size() == 0 && !in_tvalid && angles_q.size() == 0);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (errors == 0 && angles_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
